>>> rtl/lce_pkg.sv
// ----------------------------------------------------------------------------
// Life engine package
// Shared types, constants and request codes for the life engine.
// ----------------------------------------------------------------------------
package lce_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int GEN_W     = 32;

    typedef enum logic [2:0] {
        REQ_WRITE = 3'd0,
        REQ_FLIP  = 3'd1,
        REQ_READ  = 3'd2,
        REQ_STEP  = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req;

    // Classified command passed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_FLIP,
        CMD_READ,
        CMD_STEP,
        CMD_CLEAR,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             new_state;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    // Next state of one cell under the B3/S23 rule.
    function automatic logic life_rule(input logic cur, input logic [3:0] n);
        logic res;
        begin
            res = (n == 4'd3) || (cur && (n == 4'd2));
            return res;
        end
    endfunction

endpackage

>>> rtl/lce_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload with valid and ready between a source and a sink.
// ----------------------------------------------------------------------------
interface lce_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] row;
    logic [7:0] col;
    logic       new_state;
    modport source (output valid, req_type, row, col, new_state, input ready);
    modport sink   (input valid, req_type, row, col, new_state, output ready);
endinterface

interface lce_rsp_if;
    logic        valid;
    logic        ready;
    logic        cell_state;
    logic        in_range;
    logic        changed;
    logic [31:0] generation;
    modport source (output valid, cell_state, in_range, changed, generation, input ready);
    modport sink   (input valid, cell_state, in_range, changed, generation, output ready);
endinterface

>>> rtl/lce_front.sv
// ----------------------------------------------------------------------------
// Life engine front end
// Accepts request transactions, checks range and pushes commands to a queue.
// ----------------------------------------------------------------------------
module lce_front
    import lce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_row,
    input  logic [7:0] i_col,
    input  logic       i_new_state,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    // Two-entry queue.
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, in_grid;
    t_cmd       cmd;

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    assign in_grid = !i_row[7] && !i_col[7] &&
                     ({1'b0, i_row[6:0]} < 8'(GRID_ROWS)) &&
                     ({1'b0, i_col[6:0]} < 8'(GRID_COLS));

    always_comb begin
        cmd.row       = i_row[ROW_W-1:0];
        cmd.col       = i_col[COL_W-1:0];
        cmd.new_state = i_new_state;
        unique case (i_req_type)
            REQ_WRITE: cmd.kind = in_grid ? CMD_WRITE : CMD_NOP;
            REQ_FLIP:  cmd.kind = in_grid ? CMD_FLIP  : CMD_NOP;
            REQ_READ:  cmd.kind = in_grid ? CMD_READ  : CMD_NOP;
            REQ_STEP:  cmd.kind = CMD_STEP;
            REQ_CLEAR: cmd.kind = CMD_CLEAR;
            default:   cmd.kind = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule

>>> rtl/lce_back.sv
// ----------------------------------------------------------------------------
// Life engine back end
// Executes commands on the row memory and produces response transactions.
// ----------------------------------------------------------------------------
module lce_back
    import lce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_cell_state,
    output logic        o_in_range,
    output logic        o_changed,
    output logic [31:0] o_generation
);

    typedef enum logic [2:0] {
        S_IDLE, S_CELL, S_CLEAR, S_SLOAD, S_STEP, S_RESP
    } t_state;

    typedef logic [GRID_COLS-1:0] t_row;

    t_row r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_vld;  // row has been written since clear

    t_state            r_state;
    t_cmd              r_cmd;
    logic [ROW_W:0]    r_idx;     // read row index (runs past GRID_ROWS during a step)
    logic [ROW_W-1:0]  r_wr;      // row being written during a step
    t_row              r_rd;      // registered memory read
    t_row              r_prev, r_cur;
    logic              r_any;
    logic [GEN_W-1:0]  r_gen;
    logic              r_cs, r_ir, r_ch;

    t_row rd_eff, nxt_in, new_row, cell_row;
    logic [GRID_COLS+1:0] up, mid, dn;
    logic [3:0] cnt [GRID_COLS];

    assign rd_eff = r_rd;
    assign o_valid      = (r_state == S_RESP);
    assign o_cell_state = r_cs;
    assign o_in_range   = r_ir;
    assign o_changed    = r_ch;
    assign o_generation = r_gen;
    assign o_cmd_pop    = (r_state == S_IDLE) && i_cmd_valid;

    // Next row during a step: beyond the last row counts as dead.
    assign nxt_in = (r_idx > (ROW_W+1)'(GRID_ROWS)) ? '0 : rd_eff;

    always_comb begin
        up  = {1'b0, r_prev, 1'b0};
        mid = {1'b0, r_cur,  1'b0};
        dn  = {1'b0, nxt_in, 1'b0};
        for (int c = 0; c < GRID_COLS; c++) begin
            cnt[c] = 4'(up[c]) + 4'(up[c+1]) + 4'(up[c+2]) + 4'(mid[c]) +
                     4'(mid[c+2]) + 4'(dn[c]) + 4'(dn[c+1]) + 4'(dn[c+2]);
            new_row[c] = life_rule(r_cur[c], cnt[c]);
        end
        cell_row = rd_eff;
        case (r_cmd.kind)
            CMD_WRITE: cell_row[r_cmd.col] = r_cmd.new_state;
            CMD_FLIP:  cell_row[r_cmd.col] = ~rd_eff[r_cmd.col];
            default:   cell_row = rd_eff;
        endcase
    end

    // Memory read port: unwritten rows read as dead. A step starts by
    // reading row 0 while the command is taken.
    always_ff @(posedge i_clk) begin
        logic [ROW_W-1:0] ra;
        ra = (r_state == S_IDLE) ?
             ((i_cmd.kind == CMD_STEP) ? '0 : i_cmd.row) : r_idx[ROW_W-1:0];
        r_rd <= r_vld[ra] ? r_mem[ra] : '0;
        if (r_state == S_CELL && r_cmd.kind != CMD_READ) begin
            r_mem[r_cmd.row] <= cell_row;
        end else if (r_state == S_STEP) begin
            r_mem[r_wr] <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_gen   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_cs  <= 1'b0;
                        r_ir  <= 1'b0;
                        r_ch  <= 1'b0;
                        unique case (i_cmd.kind)
                            CMD_WRITE, CMD_FLIP, CMD_READ: r_state <= S_CELL;
                            CMD_STEP: begin
                                r_idx   <= (ROW_W+1)'(1);
                                r_state <= S_SLOAD;
                            end
                            CMD_CLEAR: r_state <= S_CLEAR;
                            default:   r_state <= S_RESP;
                        endcase
                    end
                end
                S_CELL: begin
                    r_cs <= cell_row[r_cmd.col];
                    r_ir <= 1'b1;
                    if (r_cmd.kind != CMD_READ) begin
                        r_vld[r_cmd.row] <= 1'b1;
                    end
                    r_state <= S_RESP;
                end
                S_CLEAR: begin
                    r_vld   <= '0;
                    r_gen   <= '0;
                    r_state <= S_RESP;
                end
                S_SLOAD: begin
                    // Row 0 arrives; row 1 read is in flight.
                    r_prev  <= '0;
                    r_cur   <= rd_eff;
                    r_wr    <= '0;
                    r_any   <= 1'b0;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_vld[r_wr] <= 1'b1;
                    r_any  <= r_any | (new_row != r_cur);
                    r_prev <= r_cur;
                    r_cur  <= nxt_in;
                    r_idx  <= r_idx + 1'b1;
                    if (r_wr == ROW_W'(GRID_ROWS-1)) begin
                        r_ch    <= r_any | (new_row != r_cur);
                        r_gen   <= r_gen + 1'b1;
                        r_state <= S_RESP;
                    end else begin
                        r_wr <= r_wr + 1'b1;
                    end
                end
                S_RESP: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/life_cellular_automaton_engine.sv
// ----------------------------------------------------------------------------
// Life cellular automaton engine
// B3/S23 grid with cell access, generation step and clear.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_req     in         req_type, row, col, new_state
//  o_rsp     out        cell_state, in_range, changed, generation
//
// In the back end a cell request runs through S_CELL and S_RESP; a step runs
// through S_SLOAD, then S_STEP for each row with one row read and one row
// write of the grid memory per cycle. Clear runs through S_CLEAR and clears
// the valid bits of the rows at once. Reset is synchronous and empties the
// queue and the grid. The two-entry command queue keeps taking transactions
// until full while the back end is busy or its response is stalled.
module life_cellular_automaton_engine
    import lce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lce_req_if.sink   i_req,
    lce_rsp_if.source o_rsp
);

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    lce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_req_type  (i_req.req_type),
        .i_row       (i_req.row),
        .i_col       (i_req.col),
        .i_new_state (i_req.new_state),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    lce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_cell_state (o_rsp.cell_state),
        .o_in_range   (o_rsp.in_range),
        .o_changed    (o_rsp.changed),
        .o_generation (o_rsp.generation)
    );

    // An out-of-range answer never reports a live cell.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.in_range |-> !o_rsp.cell_state)
        else $error("cell state set outside grid");

    // A queue pop is only possible when a command waits.
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("pop from empty queue");

    // Steps never report a cell in range.
    a_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.changed |-> !o_rsp.in_range)
        else $error("changed on cell request");

endmodule
